### hw/rtl/assert_macros.svh
// Assertion macros used by the RTL controller of the moment accumulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in moment accumulator");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in moment accumulator");

`endif

### hw/rtl/pfma_pkg.sv
// Package with the types and constants of the polynomial fit moment accumulator.
package pfma_pkg;

  localparam int MAX_COEFS = 8;
  localparam int MAX_POINTS = 65536;
  localparam int NPOW = 2 * MAX_COEFS - 1;
  localparam int DEG_W = 3;
  localparam int IDX_W = 4;
  localparam int MOM_IW = $clog2(MAX_COEFS);
  localparam int IN_W = 16;
  localparam int SUM_W = 48;
  localparam int P_W = 32;
  localparam int PROD_W = P_W + IN_W;
  localparam int ROUND_SH = 15;
  localparam int RND_W = PROD_W - ROUND_SH + 1;
  localparam int P_ONE_SH = 30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POW,
    ST_MOM,
    ST_ADV,
    ST_EMIT
  } pfma_state_t;

  typedef struct packed {
    logic             load;
    logic             acc_pow;
    logic             acc_mom;
    logic             mul_x;
    logic             advance;
    logic             emit;
    logic             clear;
    logic             kind;
    logic [IDX_W-1:0] index;
    logic             run_end;
  } pfma_cmd_t;

endpackage

### hw/rtl/pfma_ctrl.sv
// Controller state machine that sequences accumulation and emission of the sums.
`include "assert_macros.svh"

module pfma_ctrl
  import pfma_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             final_point,
  input  logic [DEG_W-1:0] fit_degree,
  output logic             busy,
  output pfma_cmd_t        cmd
);

  localparam logic [DEG_W-1:0] DEG_MAX = DEG_W'(MAX_COEFS - 1);

  pfma_state_t      state;
  pfma_state_t      state_next;
  logic [IDX_W-1:0] k;
  logic             emit_kind;
  logic [DEG_W-1:0] deg;
  logic             fin;
  logic [IDX_W-1:0] k_top;
  logic [IDX_W-1:0] k_mom;

  assign k_top = IDX_W'({deg, 1'b0});
  assign k_mom = IDX_W'(deg);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_POW;
      end
      ST_POW: begin
        state_next = (k <= k_mom) ? ST_MOM : ST_ADV;
      end
      ST_MOM: begin
        state_next = ST_ADV;
      end
      ST_ADV: begin
        if (k == k_top) state_next = fin ? ST_EMIT : ST_IDLE;
        else state_next = ST_POW;
      end
      ST_EMIT: begin
        if (emit_kind && k == k_mom) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      ST_POW: begin
        cmd.acc_pow = 1'b1;
        cmd.index = k;
        cmd.mul_x = !(k <= k_mom);
      end
      ST_MOM: begin
        cmd.acc_mom = 1'b1;
        cmd.index = k;
        cmd.mul_x = 1'b1;
      end
      ST_ADV: begin
        cmd.advance = 1'b1;
        cmd.index = k;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        cmd.kind = emit_kind;
        cmd.index = k;
        cmd.run_end = emit_kind && (k == k_mom);
        cmd.clear = emit_kind && (k == k_mom);
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k <= '0;
      emit_kind <= 1'b0;
      deg <= '0;
      fin <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && start) begin
        k <= '0;
        emit_kind <= 1'b0;
        deg <= (fit_degree > DEG_MAX) ? DEG_MAX : fit_degree;
        fin <= final_point;
      end else if (state == ST_ADV) begin
        k <= (k == k_top) ? '0 : k + 1'b1;
        emit_kind <= 1'b0;
      end else if (state == ST_EMIT) begin
        if (!emit_kind && k == k_top) begin
          emit_kind <= 1'b1;
          k <= '0;
        end else begin
          k <= k + 1'b1;
        end
      end
    end
  end

  `ASSERT_NEXT(a_accept_starts, state == ST_IDLE && start, state == ST_POW && k == '0)
  `ASSERT_SAME(a_mom_in_range, state == ST_MOM, k <= k_mom)
  `ASSERT_SAME(a_k_in_range, state != ST_IDLE, k <= k_top)
  `ASSERT_NEXT(a_run_end_idles, state == ST_EMIT && cmd.run_end, state == ST_IDLE)

endmodule

### hw/rtl/pfma_datapath.sv
// Datapath with the shared multiplier, power register and saturating sum registers.
module pfma_datapath
  import pfma_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  pfma_cmd_t               cmd,
  input  logic signed [IN_W-1:0]  x_value,
  input  logic signed [IN_W-1:0]  y_value,
  output logic                    result_strobe,
  output logic                    sum_kind,
  output logic [IDX_W-1:0]        sum_index,
  output logic signed [SUM_W-1:0] sum_value,
  output logic                    run_end
);

  logic signed [SUM_W-1:0]  power_sums [NPOW];
  logic signed [SUM_W-1:0]  moment_sums [MAX_COEFS];
  logic signed [IN_W-1:0]   x_reg;
  logic signed [IN_W-1:0]   y_reg;
  logic signed [P_W-1:0]    p;
  logic signed [PROD_W-1:0] prod;
  logic signed [IN_W-1:0]   mul_b;
  logic signed [PROD_W:0]   prod_ext;
  logic signed [RND_W-1:0]  rnd;
  logic [MOM_IW-1:0]        mom_idx;

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W:0]   b
  );
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + b;
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

  assign mul_b = cmd.mul_x ? x_reg : y_reg;
  assign prod_ext = {prod[PROD_W-1], prod} + (PROD_W+1)'(1 << (ROUND_SH - 1));
  assign rnd = prod_ext[PROD_W:ROUND_SH];
  assign mom_idx = cmd.index[MOM_IW-1:0];

  always_ff @(posedge clk) begin
    prod <= p * mul_b;
    if (cmd.load) begin
      x_reg <= x_value;
      y_reg <= y_value;
      p <= P_W'(64'(1) << P_ONE_SH);
    end else if (cmd.advance) begin
      p <= rnd[P_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NPOW; i++) power_sums[i] <= '0;
      for (int i = 0; i < MAX_COEFS; i++) moment_sums[i] <= '0;
    end else if (cmd.clear) begin
      for (int i = 0; i < NPOW; i++) power_sums[i] <= '0;
      for (int i = 0; i < MAX_COEFS; i++) moment_sums[i] <= '0;
    end else begin
      if (cmd.acc_pow) begin
        power_sums[cmd.index] <= sat_add(power_sums[cmd.index],
                                         {{(SUM_W+1-P_W){p[P_W-1]}}, p});
      end
      if (cmd.acc_mom) begin
        moment_sums[mom_idx] <= sat_add(moment_sums[mom_idx],
                                        {{(SUM_W+1-RND_W){rnd[RND_W-1]}}, rnd});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sum_kind <= cmd.kind;
      sum_index <= cmd.index;
      sum_value <= cmd.kind ? moment_sums[mom_idx] : power_sums[cmd.index];
      run_end <= cmd.run_end;
    end
  end

endmodule

### hw/rtl/poly_fit_moment_accumulator.sv
// Top level of the polynomial fit moment accumulator with its degree register.
//
// Points are taken on start while busy is low. With fit degree d, each point
// keeps the block busy after it is taken while the single shared multiplier
// forms every power of x and every y product in turn, so a new point can only
// be taken once the previous one is done. On a point marked final, busy stays
// high through the emission of 3d+2 result words, which follow in consecutive
// cycles, S_0..S_2d then T_0..T_d, each shown for one cycle with
// result_strobe; the receiver cannot stall them and must take each word in its
// cycle. The next point can follow once busy falls again. run_end marks the
// last word, and all sums are cleared as it is sent. Write fit_degree
// only while busy is low.
module poly_fit_moment_accumulator
  import pfma_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fit_degree_write,
  input  logic [DEG_W-1:0]        fit_degree_data,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [IN_W-1:0]  x_value,
  input  logic signed [IN_W-1:0]  y_value,
  input  logic                    final_point,
  output logic                    result_strobe,
  output logic                    sum_kind,
  output logic [IDX_W-1:0]        sum_index,
  output logic signed [SUM_W-1:0] sum_value,
  output logic                    run_end
);

  logic [DEG_W-1:0] fit_degree;
  pfma_cmd_t        cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_degree <= DEG_W'(1);
    end else if (fit_degree_write) begin
      fit_degree <= fit_degree_data;
    end
  end

  pfma_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .final_point (final_point),
    .fit_degree  (fit_degree),
    .busy        (busy),
    .cmd         (cmd)
  );

  pfma_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .x_value       (x_value),
    .y_value       (y_value),
    .result_strobe (result_strobe),
    .sum_kind      (sum_kind),
    .sum_index     (sum_index),
    .sum_value     (sum_value),
    .run_end       (run_end)
  );

endmodule
